// ===== sv/bpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types and constants for the barometric compensation pipeline.
// ----------------------------------------------------------------------------
package bpc_pkg;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned DIV_W       = 32;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_AC1_AC2 = 3'd0,
        REG_AC3_AC4 = 3'd1,
        REG_AC5_AC6 = 3'd2,
        REG_B1_B2   = 3'd3,
        REG_MC_MD   = 3'd4,
        REG_OSS     = 3'd5
    } reg_index_t;

    localparam logic [31:0] B6_OFFSET  = 32'd4000;
    localparam logic [31:0] B4_OFFSET  = 32'd32768;
    localparam logic [31:0] B7_SCALE   = 32'd50000;
    localparam logic [31:0] P_COEF_A   = 32'd3038;
    localparam logic [31:0] P_COEF_B   = 32'hFFFF_E343;
    localparam logic [31:0] P_COEF_C   = 32'd3791;

endpackage

// ===== sv/bpc_udiv.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_udiv
// Pipelined unsigned restoring divider, one quotient bit per stage, with a
// side payload carried alongside and a shared stall enable.
// ----------------------------------------------------------------------------
module bpc_udiv #(
    parameter int unsigned WIDTH   = bpc_pkg::DIV_W,
    parameter int unsigned SIDE_W  = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [WIDTH-1:0]  dividend,
    input  logic [WIDTH-1:0]  divisor,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [WIDTH-1:0]  quotient,
    output logic [SIDE_W-1:0] side_out
);

    logic [WIDTH-1:0]  rem_reg  [WIDTH+1];
    logic [WIDTH-1:0]  num_reg  [WIDTH+1];
    logic [WIDTH-1:0]  den_reg  [WIDTH+1];
    logic [SIDE_W-1:0] side_reg [WIDTH+1];
    logic [WIDTH:0]    vld_reg;

    always_comb
    begin
        rem_reg[0]  = '0;
        num_reg[0]  = dividend;
        den_reg[0]  = divisor;
        side_reg[0] = side_in;
        vld_reg[0]  = in_valid;
    end

    for (genvar s = 0; s < WIDTH; s++) begin : g_stage
        logic [WIDTH:0]   trial;
        logic [WIDTH:0]   diff;
        always_comb
        begin
            trial = {rem_reg[s], num_reg[s][WIDTH-1]};
            diff  = trial - {1'b0, den_reg[s]};
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[s+1] <= vld_reg[s];
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!diff[WIDTH])
                begin
                    rem_reg[s+1] <= diff[WIDTH-1:0];
                end
                else
                begin
                    rem_reg[s+1] <= trial[WIDTH-1:0];
                end
                num_reg[s+1]  <= {num_reg[s][WIDTH-2:0], ~diff[WIDTH]};
                den_reg[s+1]  <= den_reg[s];
                side_reg[s+1] <= side_reg[s];
            end
        end
    end

    assign out_valid = vld_reg[WIDTH];
    assign quotient  = num_reg[WIDTH];
    assign side_out  = side_reg[WIDTH];

endmodule

// ===== sv/baro_pressure_temp_compensation.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation
// Integer temperature and pressure compensation for a barometric sensor.
//
// Channel  Direction  Handshake               Payload
// s_axis   in         s_axis_tvalid/tready    raw temperature, raw pressure
// m_axis   out        m_axis_tvalid/tready    temperature, pressure, error
// cfg      in         cfg_valid/cfg_ready     register index, 32-bit data
//
// One request per cycle unless the skid register is full; a request passes
// two set-up stages, a 32-stage temperature divider, five multiply stages,
// a 32-stage pressure divider, two correction stages and the output register.
// Reset clears the valid bits and the registers to their defaults.
// A stall at the output parks one result in a skid register, then freezes
// the pipeline and holds off the input from the next cycle; nothing is lost.
// ----------------------------------------------------------------------------
module baro_pressure_temp_compensation (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [15:0] raw_temperature, [34:16] raw_pressure, [39:35] zero
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] temperature_tenths, [47:16] pressure_pascal
    output logic [47:0] m_axis_tdata,
    // [0] divide_error
    output logic        m_axis_tuser,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [bpc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int unsigned DW = bpc_pkg::DIV_W;

    logic [31:0] ac12_reg, ac34_reg, ac56_reg, b12_reg, mcmd_reg;
    logic [1:0]  oss_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ac12_reg <= '0;
            ac34_reg <= '0;
            ac56_reg <= '0;
            b12_reg  <= '0;
            mcmd_reg <= '0;
            oss_reg  <= 2'd3;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                bpc_pkg::REG_AC1_AC2: ac12_reg <= cfg_data;
                bpc_pkg::REG_AC3_AC4: ac34_reg <= cfg_data;
                bpc_pkg::REG_AC5_AC6: ac56_reg <= cfg_data;
                bpc_pkg::REG_B1_B2:   b12_reg  <= cfg_data;
                bpc_pkg::REG_MC_MD:   mcmd_reg <= cfg_data;
                bpc_pkg::REG_OSS:     oss_reg  <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    always_comb
    begin
        ac1 = {{16{ac12_reg[31]}}, ac12_reg[31:16]};
        ac2 = {{16{ac12_reg[15]}}, ac12_reg[15:0]};
        ac3 = {{16{ac34_reg[31]}}, ac34_reg[31:16]};
        ac4 = {16'd0, ac34_reg[15:0]};
        ac5 = {16'd0, ac56_reg[31:16]};
        ac6 = {16'd0, ac56_reg[15:0]};
        b1  = {{16{b12_reg[31]}}, b12_reg[31:16]};
        b2  = {{16{b12_reg[15]}}, b12_reg[15:0]};
        mc  = {{16{mcmd_reg[31]}}, mcmd_reg[31:16]};
        md  = {{16{mcmd_reg[15]}}, mcmd_reg[15:0]};
    end

    // Output register with a skid slot; the pipeline advances while the slot is free.
    logic        ov_reg;
    logic [47:0] od_reg;
    logic        oe_reg;
    logic        sk_v_reg;
    logic [47:0] sk_d_reg;
    logic        sk_e_reg;
    logic        out_free;
    logic        en;
    logic        tail_valid;
    logic [47:0] tail_data;
    logic        tail_err;

    assign out_free      = !ov_reg || m_axis_tready;
    assign en            = !sk_v_reg;
    assign s_axis_tready = en;

    // Stage 1: x1 = asr((ut - ac6) * ac5, 15)
    logic        v1_reg;
    logic [31:0] x1t_reg;
    logic [18:0] up1_reg;
    logic [31:0] mul1;
    assign mul1 = ({16'd0, s_axis_tdata[15:0]} - ac6) * ac5;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= s_axis_tvalid;
        end
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1t_reg <= $unsigned($signed(mul1) >>> 15);
            up1_reg <= s_axis_tdata[34:16];
        end
    end

    // Stage 2: set up signed divide (mc << 11) / (x1 + md)
    logic        v2_reg;
    logic [31:0] x1t2_reg, na_reg, nb_reg;
    logic        neg2_reg, z2_reg;
    logic [18:0] up2_reg;
    logic [31:0] tnum, tden;
    assign tnum = mc << 11;
    assign tden = x1t_reg + md;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= v1_reg;
        end
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1t2_reg <= x1t_reg;
            na_reg   <= tnum[31] ? 32'd0 - tnum : tnum;
            nb_reg   <= tden[31] ? 32'd0 - tden : tden;
            neg2_reg <= tnum[31] ^ tden[31];
            z2_reg   <= (tden == 32'd0);
            up2_reg  <= up1_reg;
        end
    end

    localparam int unsigned S1_W = 32 + 1 + 1 + 19;
    logic            v3;
    logic [31:0]     q3;
    logic [S1_W-1:0] s3;

    bpc_udiv #(.WIDTH(DW), .SIDE_W(S1_W)) u_tdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v2_reg),
        .dividend  (na_reg),
        .divisor   (nb_reg),
        .side_in   ({x1t2_reg, neg2_reg, z2_reg, up2_reg}),
        .out_valid (v3),
        .quotient  (q3),
        .side_out  (s3)
    );

    // Stage 4: b5, t, b6
    logic        v4_reg;
    logic [31:0] b6_reg;
    logic [15:0] t4_reg;
    logic        e4_reg;
    logic [18:0] up4_reg;
    logic [31:0] x2t, b5c, tc;
    logic [15:0] tsat;
    always_comb
    begin
        x2t = s3[19] ? 32'd0 : (s3[20] ? 32'd0 - q3 : q3);
        b5c = s3[S1_W-1 -: 32] + x2t;
        tc  = $unsigned($signed(b5c + 32'd8) >>> 4);
        if ($signed(tc) < -32'sd32768)
        begin
            tsat = 16'h8000;
        end
        else if ($signed(tc) > 32'sd32767)
        begin
            tsat = 16'h7FFF;
        end
        else
        begin
            tsat = tc[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v4_reg <= v3;
        end
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b6_reg  <= b5c - bpc_pkg::B6_OFFSET;
            t4_reg  <= tsat;
            e4_reg  <= s3[19];
            up4_reg <= s3[18:0];
        end
    end

    // Stage 5: b6sq, ac2*b6, ac3*b6
    logic        v5_reg;
    logic [31:0] b6sq_reg, m2_reg, m3_reg;
    logic [15:0] t5_reg;
    logic        e5_reg;
    logic [18:0] up5_reg;
    logic [31:0] sq, p2, p3;
    assign sq = b6_reg * b6_reg;
    assign p2 = ac2 * b6_reg;
    assign p3 = ac3 * b6_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v5_reg <= v4_reg;
        end
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b6sq_reg <= $unsigned($signed(sq) >>> 12);
            m2_reg   <= $unsigned($signed(p2) >>> 11);
            m3_reg   <= $unsigned($signed(p3) >>> 13);
            t5_reg   <= t4_reg;
            e5_reg   <= e4_reg;
            up5_reg  <= up4_reg;
        end
    end

    // Stage 6: b2*b6sq, b1*b6sq
    logic        v6_reg;
    logic [31:0] m4_reg, m5_reg, m2b_reg, m3b_reg;
    logic [15:0] t6_reg;
    logic        e6_reg;
    logic [18:0] up6_reg;
    logic [31:0] p4, p5;
    assign p4 = b2 * b6sq_reg;
    assign p5 = b1 * b6sq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v6_reg <= 1'b0;
        end
        else if (en)
        begin
            v6_reg <= v5_reg;
        end
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m4_reg  <= $unsigned($signed(p4) >>> 11);
            m5_reg  <= $unsigned($signed(p5) >>> 16);
            m2b_reg <= m2_reg;
            m3b_reg <= m3_reg;
            t6_reg  <= t5_reg;
            e6_reg  <= e5_reg;
            up6_reg <= up5_reg;
        end
    end

    // Stage 7: b3, b4 operand
    logic        v7_reg;
    logic [31:0] b3_reg, x3b_reg;
    logic [15:0] t7_reg;
    logic        e7_reg;
    logic [18:0] up7_reg;
    logic [31:0] x3a, b3c, x3c;
    always_comb
    begin
        x3a = m4_reg + m2b_reg;
        b3c = $unsigned($signed(((ac1 * 32'd4 + x3a) << oss_reg) + 32'd2) >>> 2);
        x3c = $unsigned($signed(m3b_reg + m5_reg + 32'd2) >>> 2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v7_reg <= 1'b0;
        end
        else if (en)
        begin
            v7_reg <= v6_reg;
        end
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b3_reg  <= b3c;
            x3b_reg <= x3c + bpc_pkg::B4_OFFSET;
            t7_reg  <= t6_reg;
            e7_reg  <= e6_reg;
            up7_reg <= up6_reg;
        end
    end

    // Stage 8: b4, b7
    logic        v8_reg;
    logic [31:0] b4_reg, b7_reg;
    logic [15:0] t8_reg;
    logic        e8_reg;
    logic [31:0] b4p, b7p;
    assign b4p = ac4 * x3b_reg;
    assign b7p = ({13'd0, up7_reg} - b3_reg) * (bpc_pkg::B7_SCALE >> oss_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v8_reg <= 1'b0;
        end
        else if (en)
        begin
            v8_reg <= v7_reg;
        end
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b4_reg <= b4p >> 15;
            b7_reg <= b7p;
            t8_reg <= t7_reg;
            e8_reg <= e7_reg;
        end
    end

    localparam int unsigned S2_W = 16 + 1 + 1 + 1;
    logic            v9;
    logic [31:0]     q9;
    logic [S2_W-1:0] s9;
    logic [31:0]     pnum;
    assign pnum = b7_reg[31] ? b7_reg : (b7_reg << 1);

    bpc_udiv #(.WIDTH(DW), .SIDE_W(S2_W)) u_pdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v8_reg),
        .dividend  (pnum),
        .divisor   (b4_reg),
        .side_in   ({t8_reg, e8_reg, (b4_reg == 32'd0), b7_reg[31]}),
        .out_valid (v9),
        .quotient  (q9),
        .side_out  (s9)
    );

    // Stage 10: p and its first products
    logic        v10_reg;
    logic [31:0] p10_reg, sq10_reg, lin10_reg;
    logic [15:0] t10_reg;
    logic        e10_reg;
    logic [31:0] pc, ps;
    always_comb
    begin
        pc = s9[1] ? 32'd0 : (s9[0] ? (q9 << 1) : q9);
        ps = $unsigned($signed(pc) >>> 8);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v10_reg <= 1'b0;
        end
        else if (en)
        begin
            v10_reg <= v9;
        end
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p10_reg   <= pc;
            sq10_reg  <= ps * ps;
            lin10_reg <= bpc_pkg::P_COEF_B * pc;
            t10_reg   <= s9[S2_W-1 -: 16];
            e10_reg   <= s9[2] | s9[1];
        end
    end

    // Stage 11: scale square
    logic        v11_reg;
    logic [31:0] p11_reg, x1_11_reg, x2_11_reg;
    logic [15:0] t11_reg;
    logic        e11_reg;
    logic [31:0] sqm;
    assign sqm = sq10_reg * bpc_pkg::P_COEF_A;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v11_reg <= 1'b0;
        end
        else if (en)
        begin
            v11_reg <= v10_reg;
        end
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p11_reg   <= p10_reg;
            x1_11_reg <= $unsigned($signed(sqm) >>> 16);
            x2_11_reg <= $unsigned($signed(lin10_reg) >>> 16);
            t11_reg   <= t10_reg;
            e11_reg   <= e10_reg;
        end
    end

    logic [31:0] pfin;
    assign pfin = p11_reg +
        $unsigned($signed(x1_11_reg + x2_11_reg + bpc_pkg::P_COEF_C) >>> 4);
    assign tail_valid = v11_reg;
    assign tail_data  = {pfin, t11_reg};
    assign tail_err   = e11_reg;

    // Drain the skid slot first; park the tail request there when the output is held.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg   <= 1'b0;
            sk_v_reg <= 1'b0;
        end
        else if (sk_v_reg)
        begin
            if (out_free)
            begin
                ov_reg   <= 1'b1;
                sk_v_reg <= 1'b0;
            end
        end
        else if (out_free)
        begin
            ov_reg <= tail_valid;
        end
        else if (tail_valid)
        begin
            sk_v_reg <= 1'b1;
        end
    end
    always_ff @(posedge clk)
    begin
        if (sk_v_reg)
        begin
            if (out_free)
            begin
                od_reg <= sk_d_reg;
                oe_reg <= sk_e_reg;
            end
        end
        else if (out_free)
        begin
            od_reg <= tail_data;
            oe_reg <= tail_err;
        end
        else
        begin
            sk_d_reg <= tail_data;
            sk_e_reg <= tail_err;
        end
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = od_reg;
    assign m_axis_tuser  = oe_reg;

endmodule

// ===== dv/bpc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_checker
// Watches the request, result and register channels of the barometric
// compensation block, computes the expected temperature, pressure and
// error flag for every accepted request, and compares each result in order.
// ----------------------------------------------------------------------------
module bpc_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [47:0] m_axis_tdata,
    input  logic        m_axis_tuser,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [bpc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0] cfg_data,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [15:0] temperature;
        logic [31:0] pressure;
        logic        div_err;
    } comp_result_t;

    comp_result_t compensated_q[$];

    logic [31:0] cal_ac1_ac2, cal_ac3_ac4, cal_ac5_ac6, cal_b1_b2, cal_mc_md;
    logic [1:0]  cal_oss;

    function automatic logic [31:0] sext16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] sra(input logic [31:0] v, input int n);
        return $unsigned($signed(v) >>> n);
    endfunction

    function automatic logic [31:0] sdiv32(input logic [31:0] a, input logic [31:0] b,
                                           inout logic err);
        logic [31:0] ma, mb, q;
        if (b == 0)
        begin
            err = 1'b1;
            return 32'd0;
        end
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        q  = ma / mb;
        return (a[31] != b[31]) ? -q : q;
    endfunction

    function automatic comp_result_t compensate(input logic [15:0] ut16,
                                                input logic [18:0] up19);
        logic [31:0] ut, up, ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
        logic [31:0] x1, x2, x3, b5, t, b6, b6sq, b3, b4, b7, p;
        logic        err;
        comp_result_t r;
        ut  = {16'd0, ut16};
        up  = {13'd0, up19};
        ac1 = sext16(cal_ac1_ac2[31:16]);
        ac2 = sext16(cal_ac1_ac2[15:0]);
        ac3 = sext16(cal_ac3_ac4[31:16]);
        ac4 = {16'd0, cal_ac3_ac4[15:0]};
        ac5 = {16'd0, cal_ac5_ac6[31:16]};
        ac6 = {16'd0, cal_ac5_ac6[15:0]};
        b1  = sext16(cal_b1_b2[31:16]);
        b2  = sext16(cal_b1_b2[15:0]);
        mc  = sext16(cal_mc_md[31:16]);
        md  = sext16(cal_mc_md[15:0]);
        err = 1'b0;
        x1 = sra((ut - ac6) * ac5, 15);
        x2 = sdiv32(mc << 11, x1 + md, err);
        b5 = x1 + x2;
        t  = sra(b5 + 32'd8, 4);
        if ($signed(t) < -32768)
            t = 32'hFFFF_8000;
        else if ($signed(t) > 32767)
            t = 32'h0000_7FFF;
        b6   = b5 - bpc_pkg::B6_OFFSET;
        b6sq = sra(b6 * b6, 12);
        x1 = sra(b2 * b6sq, 11);
        x2 = sra(ac2 * b6, 11);
        x3 = x1 + x2;
        b3 = sra(((ac1 * 32'd4 + x3) << cal_oss) + 32'd2, 2);
        x1 = sra(ac3 * b6, 13);
        x2 = sra(b1 * b6sq, 16);
        x3 = sra(x1 + x2 + 32'd2, 2);
        b4 = (ac4 * (x3 + bpc_pkg::B4_OFFSET)) >> 15;
        b7 = (up - b3) * (bpc_pkg::B7_SCALE >> cal_oss);
        if (b4 == 0)
        begin
            err = 1'b1;
            p = 32'd0;
        end
        else if (!b7[31])
            p = (b7 << 1) / b4;
        else
            p = (b7 / b4) << 1;
        x1 = sra(p, 8) * sra(p, 8);
        x1 = sra(x1 * bpc_pkg::P_COEF_A, 16);
        x2 = sra(bpc_pkg::P_COEF_B * p, 16);
        p  = p + sra(x1 + x2 + bpc_pkg::P_COEF_C, 4);
        r.temperature = t[15:0];
        r.pressure    = p;
        r.div_err     = err;
        return r;
    endfunction

    task automatic report(input string what, input logic [31:0] got,
                          input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    assign pending = compensated_q.size();

    initial fail_count = 0;

    always @(posedge clk or negedge rst_n)
    begin
        comp_result_t want;
        if (!rst_n)
        begin
            cal_ac1_ac2 <= '0;
            cal_ac3_ac4 <= '0;
            cal_ac5_ac6 <= '0;
            cal_b1_b2   <= '0;
            cal_mc_md   <= '0;
            cal_oss     <= 2'd3;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    bpc_pkg::REG_AC1_AC2: cal_ac1_ac2 <= cfg_data;
                    bpc_pkg::REG_AC3_AC4: cal_ac3_ac4 <= cfg_data;
                    bpc_pkg::REG_AC5_AC6: cal_ac5_ac6 <= cfg_data;
                    bpc_pkg::REG_B1_B2:   cal_b1_b2   <= cfg_data;
                    bpc_pkg::REG_MC_MD:   cal_mc_md   <= cfg_data;
                    bpc_pkg::REG_OSS:     cal_oss     <= cfg_data[1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                compensated_q.push_back(compensate(s_axis_tdata[15:0],
                                                   s_axis_tdata[34:16]));
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (compensated_q.size() == 0)
                    report("unexpected result", m_axis_tdata[47:16], 32'd0);
                else
                begin
                    want = compensated_q.pop_front();
                    if (m_axis_tdata[15:0] !== want.temperature)
                        report("temperature", {16'd0, m_axis_tdata[15:0]},
                               {16'd0, want.temperature});
                    if (m_axis_tdata[47:16] !== want.pressure)
                        report("pressure", m_axis_tdata[47:16], want.pressure);
                    if (m_axis_tuser !== want.div_err)
                        report("divide error", {31'd0, m_axis_tuser},
                               {31'd0, want.div_err});
                end
            end
        end
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the barometric compensation block: programs
// several calibration sets, including extremes and zero divisors, and sends
// directed and random raw readings with random gaps and output stalls.
// ----------------------------------------------------------------------------
module testbench;

    localparam int  LATENCY   = 200;
    localparam longint MAX_CYCLES = 400000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [bpc_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [31:0] cfg_data;
    int          fail_count;
    int          pending;
    longint      cycle_count;
    bit          hold_sink;

    baro_pressure_temp_compensation dut (.*);

    bpc_checker checker_i (.*);

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > MAX_CYCLES)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // output side: one random wait per result, or a long hold when asked
    initial
    begin
        int w;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
            m_axis_tready = 1'b0;
            repeat (w) @(negedge clk);
            while (hold_sink) @(negedge clk);
            m_axis_tready = 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            @(negedge clk);
        end
    end

    task automatic write_reg(input bpc_pkg::reg_index_t idx, input logic [31:0] v);
        cfg_index = idx;
        cfg_data  = v;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic load_calibration(input logic [31:0] r0, r1, r2, r3, r4,
                                    input logic [1:0] oss);
        while (pending != 0) @(negedge clk);
        repeat (LATENCY) @(negedge clk);
        write_reg(bpc_pkg::REG_AC1_AC2, r0);
        write_reg(bpc_pkg::REG_AC3_AC4, r1);
        write_reg(bpc_pkg::REG_AC5_AC6, r2);
        write_reg(bpc_pkg::REG_B1_B2, r3);
        write_reg(bpc_pkg::REG_MC_MD, r4);
        write_reg(bpc_pkg::REG_OSS, {30'd0, oss});
    endtask

    task automatic send_reading(input logic [15:0] ut, input logic [18:0] up,
                                input int gap);
        repeat (gap) @(negedge clk);
        s_axis_tdata  = {5'd0, up, ut};
        s_axis_tvalid = 1'b1;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        @(negedge clk);
        s_axis_tvalid = 1'b0;
    endtask

    function automatic int draw_gap();
        return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
    endfunction

    initial
    begin
        logic [15:0] ut;
        logic [18:0] up;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_valid = 1'b0;
        cfg_index = bpc_pkg::REG_AC1_AC2;
        cfg_data  = '0;
        hold_sink = 1'b0;
        cycle_count = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset defaults: every divisor zero
        send_reading(16'd0, 19'd0, 0);
        send_reading(16'hFFFF, 19'h7FFFF, 0);

        // typical datasheet calibration
        load_calibration({16'd408, -16'sd72}, {-16'sd14383, 16'd32741},
                         {16'd32757, 16'd23153}, {16'd6190, 16'd4},
                         {-16'sd8711, 16'd2868}, 2'd0);
        send_reading(16'd27898, 19'd23843, 0);
        send_reading(16'd0, 19'd0, 1);
        send_reading(16'hFFFF, 19'h7FFFF, 0);
        send_reading(16'h8000, 19'h40000, 0);
        send_reading(16'd23153, 19'd1, 2);

        // extreme coefficients, saturating temperature
        load_calibration(32'h7FFF_8000, 32'h8000_FFFF, 32'hFFFF_FFFF,
                         32'h7FFF_8000, 32'h7FFF_0001, 2'd3);
        send_reading(16'hFFFF, 19'h7FFFF, 0);
        send_reading(16'd0, 19'd0, 0);
        send_reading(16'd1, 19'h55555, 0);
        send_reading(16'h7FFF, 19'h2AAAA, 0);

        // temperature divisor zero: x1 = 0 with md = 0
        load_calibration(32'h0001_0001, 32'h0001_0001, 32'h0000_0000,
                         32'h0000_0000, 32'h1234_0000, 2'd1);
        send_reading(16'd100, 19'd500, 0);
        send_reading(16'hFFFF, 19'd0, 0);

        // signed divide case: mc<<11 = -2^26, x1+md = -1
        load_calibration(32'h0000_0000, 32'h0000_8000, 32'h0000_0000,
                         32'h0000_0000, 32'h8000_FFFF, 2'd2);
        send_reading(16'd5, 19'd7, 0);
        send_reading(16'd6000, 19'd300000, 0);

        // long output hold while requests keep coming
        load_calibration({16'd408, -16'sd72}, {-16'sd14383, 16'd32741},
                         {16'd32757, 16'd23153}, {16'd6190, 16'd4},
                         {-16'sd8711, 16'd2868}, 2'd3);
        hold_sink = 1'b1;
        fork
            begin
                repeat (400) @(negedge clk);
                hold_sink = 1'b0;
            end
            for (int i = 0; i < 150; i++)
                send_reading(16'(16'd20000 + $urandom_range(0, 15000)),
                             19'($urandom_range(0, 19'h7FFFF)), 0);
        join

        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph % 2 == 0)
                load_calibration($urandom, $urandom, $urandom, $urandom, $urandom,
                                 2'($urandom_range(0, 3)));
            else
                load_calibration({16'($urandom_range(0, 800)),
                                  16'($signed(-$urandom_range(0, 2000)))},
                                 {16'($signed(-$urandom_range(1, 20000))),
                                  16'($urandom_range(20000, 40000))},
                                 {16'($urandom_range(20000, 40000)),
                                  16'($urandom_range(15000, 30000))},
                                 {16'($urandom_range(4000, 8000)),
                                  16'($urandom_range(0, 100))},
                                 {16'($signed(-$urandom_range(5000, 12000))),
                                  16'($urandom_range(1000, 4000))},
                                 2'($urandom_range(0, 3)));
            for (int i = 0; i < 300; i++)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    ut = 16'($urandom);
                    up = 19'($urandom);
                end
                else
                begin
                    ut = 16'($urandom_range(15000, 40000));
                    up = 19'($urandom_range(10000, 100000) << ph % 4);
                end
                send_reading(ut, up, (ph == 2) ? 0 : draw_gap());
            end
        end

        while (pending != 0) @(negedge clk);
        repeat (LATENCY) @(negedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== baro_pressure_temp_compensation.f =====
sv/bpc_pkg.sv
sv/bpc_udiv.sv
sv/baro_pressure_temp_compensation.sv
dv/bpc_checker.sv
dv/testbench.sv
